FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the DDS function generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property p must hold on every clock edge out of reset
`define ASSERT_CLK(label, clk, rstn, p, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (p)) else $error(msg);

// antecedent a implies consequent c on the next clock edge
`define ASSERT_NEXT(label, clk, rstn, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);

`endif

FILE: rtl/dds_fg_pkg.sv
// ----------------------------------------------------------------------------
// dds_fg_pkg
// Shared types, constants and math helpers for the DDS function generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dds_fg_pkg;

    localparam int PHASE_BITS_DEF       = 32;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int INDEX_BITS_DEF       = 24;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_OFS = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TUNE      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SWEEP_END = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SWEEP_LEN = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_MOD_TUNE  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_MOD_DEPTH = 3'd7;

    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_SQUARE   = 2'd1;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd2;
    localparam logic [1:0] WAVE_SAW      = 2'd3;

    localparam logic [1:0] SWEEP_LIN = 2'd1;
    localparam logic [1:0] SWEEP_LOG = 2'd2;

    localparam logic [15:0] AMP_MAX   = 16'd40960;
    localparam logic [15:0] DEPTH_MAX = 16'd32768;
    localparam logic [16:0] ONE_Q16   = 17'd65536;

    localparam int SAMPLE_W = 22;
    localparam int NUMBER_W = 24;

    // job the back end needs: carrier increment, restart, burst index and last flag
    typedef struct packed {
        logic [31:0]        inc;        // carrier increment word
        logic               restart;
        logic [NUMBER_W-1:0] number;
        logic               last;
    } job_t;

    // sine of k/depth of a cycle in Q.16, Taylor series over the quarter wave
    function automatic logic signed [17:0] sine_entry(input int unsigned k, input int depth);
        logic [63:0] u, q, r, x, x2, t, s;
        u = (64'(k) << 32) / 64'(depth);
        q = (u >> 30) & 64'd3;
        r = u & 64'h3FFF_FFFF;
        if (q[0]) r = 64'h4000_0000 - r;
        x  = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t  = 64'h4000_0000 - x2 / 64'd110;
        t  = 64'h4000_0000 - ((x2 * t) >> 30) / 64'd72;
        t  = 64'h4000_0000 - ((x2 * t) >> 30) / 64'd42;
        t  = 64'h4000_0000 - ((x2 * t) >> 30) / 64'd20;
        t  = 64'h4000_0000 - ((x2 * t) >> 30) / 64'd6;
        s  = (((x * t) >> 30) + 64'd8192) >> 14;
        if (s > 64'd65536) s = 64'd65536;
        return q[1] ? -$signed(18'(s)) : $signed(18'(s));
    endfunction

    // integer square root, elaboration use only
    function automatic logic [63:0] isqrt64(input logic [63:0] xin);
        logic [63:0] x, res, b;
        x = xin;
        res = '0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // 2^(2^-i) in Q30, i = 1..16, same recurrence as the fixed-point exp2
    function automatic logic [31:0] exp2_const(input int i);
        logic [63:0] c;
        c = isqrt64(64'd1 << 61);
        for (int j = 1; j < i; j++) c = isqrt64(c << 30);
        return c[31:0];
    endfunction

endpackage

FILE: rtl/dds_fg_front.sv
// ----------------------------------------------------------------------------
// dds_fg_front
// Accepts restart beats, tracks the burst index and works out the carrier
// increment (fixed, linear sweep or log sweep) with shared serial units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dds_fg_front #(
    parameter int INDEX_BITS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_restart,
    input  logic [4:0]           mode,
    input  logic [31:0]          tuning_word,
    input  logic [31:0]          sweep_end_word,
    input  logic [23:0]          sweep_length,
    output logic                 job_valid,
    input  logic                 job_ready,
    output dds_fg_pkg::job_t     job
);
    import dds_fg_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LOGA  = 9'b000000010,
        S_LOGB  = 9'b000000100,
        S_MUL   = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_EXP   = 9'b000100000,
        S_RND   = 9'b001000000,
        S_PUSH  = 9'b010000000,
        S_LMUL  = 9'b100000000
    } st_t;

    localparam logic [INDEX_BITS-1:0] IMAX = '1;

    // 2^(2^-i) in Q30 for exp2 step i = 1..16
    localparam logic [31:0] CK_TAB [16] = '{
        exp2_const(1),  exp2_const(2),  exp2_const(3),  exp2_const(4),
        exp2_const(5),  exp2_const(6),  exp2_const(7),  exp2_const(8),
        exp2_const(9),  exp2_const(10), exp2_const(11), exp2_const(12),
        exp2_const(13), exp2_const(14), exp2_const(15), exp2_const(16)
    };

    st_t                  st_reg, st_next;
    logic [INDEX_BITS-1:0] idx_reg;
    logic                 restart_reg;
    logic [31:0]          s_w, e_w;
    logic [31:0]          inc_reg;
    logic [20:0]          la_reg, lb_reg;
    // log2 unit
    logic [31:0]          m_reg;
    logic [4:0]           cnt_reg;
    // lerp unit: diff*idx / len, restoring divider one bit a cycle
    logic [55:0]          num_reg;
    logic [55:0]          quo_reg;
    logic [56:0]          rem_reg;
    logic [5:0]           dcnt_reg;
    logic                 down_reg;
    logic [31:0]          base_reg;
    // exp2 unit
    logic [31:0]          r_reg;
    logic [15:0]          frac_reg;
    logic [4:0]           n_reg;
    logic [31:0]          ck;
    logic [NUMBER_W-1:0]  cur_idx;
    logic                 sweeping, past_end;
    logic [1:0]           sel;
    logic [63:0]          sq;
    logic [63:0]          rc;
    logic [4:0]           msb;
    logic [56:0]          rem_sh;
    logic [31:0]          diff;
    logic [63:0]          vexp;

    assign s_w = (tuning_word == 32'd0) ? 32'd1 : tuning_word;
    assign e_w = (sweep_end_word == 32'd0) ? 32'd1 : sweep_end_word;
    assign sel = mode[3:2];
    assign cur_idx = in_restart ? '0 : NUMBER_W'(idx_reg);

    // index compared at full width for the sweep, the model uses idx >= len
    logic [INDEX_BITS-1:0] eff_idx_reg;
    always_comb begin
        past_end = ({8'd0, eff_idx_reg} >= {8'd0, sweep_length}) || (sweep_length == 24'd0);
    end

    assign in_ready  = (st_reg == S_IDLE) && !job_valid;
    assign sweeping  = (sel == SWEEP_LIN) || (sel == SWEEP_LOG);

    assign sq = 64'(m_reg) * 64'(m_reg);
    assign ck = CK_TAB[4'(cnt_reg - 5'd1)];
    assign rc = 64'(r_reg) * 64'(ck);

    always_comb begin
        msb = 5'd0;
        for (int b = 1; b < 32; b++) if (m_reg[b]) msb = 5'(b);
    end

    assign rem_sh = {rem_reg[55:0], num_reg[55]};
    assign vexp = (n_reg >= 5'd30) ? (64'(r_reg) << (n_reg - 5'd30))
                : ((64'(r_reg) + (64'd1 << (5'd29 - n_reg))) >> (5'd30 - n_reg));

    logic [31:0] lo_a, hi_b;
    assign lo_a = (sel == SWEEP_LOG) ? {11'd0, la_reg} : s_w;
    assign hi_b = (sel == SWEEP_LOG) ? {11'd0, lb_reg} : e_w;
    assign diff = (hi_b >= lo_a) ? hi_b - lo_a : lo_a - hi_b;

    logic        job_valid_reg;
    job_t        job_reg;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    // log2 normalize helper for one operand
    function automatic logic [31:0] norm(input logic [31:0] w, input logic [4:0] mb);
        return (mb <= 5'd30) ? (w << (5'd30 - mb)) : (w >> 1);
    endfunction

    logic [4:0] msb_s, msb_e;
    always_comb begin
        msb_s = 5'd0;
        msb_e = 5'd0;
        for (int b = 1; b < 32; b++) begin
            if (s_w[b]) msb_s = 5'(b);
            if (e_w[b]) msb_e = 5'(b);
        end
    end

    logic [31:0] sq_hi;
    assign sq_hi = sq[61:30];

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:  if (in_valid && in_ready) begin
                         if (!sweeping) st_next = S_PUSH;
                         else if (sel == SWEEP_LOG) st_next = S_LOGA;
                         else st_next = S_LMUL;
                     end
            S_LOGA:  if (cnt_reg == 5'd15) st_next = S_LOGB;
            S_LOGB:  if (cnt_reg == 5'd15) st_next = S_LMUL;
            S_LMUL:  st_next = past_end ? ((sel == SWEEP_LOG) ? S_EXP : S_PUSH) : S_DIV;
            S_MUL:   st_next = S_DIV;
            S_DIV:   if (dcnt_reg == 6'd55) st_next = (sel == SWEEP_LOG) ? S_EXP : S_RND;
            S_EXP:   if (cnt_reg == 5'd16) st_next = S_RND;
            S_RND:   st_next = S_PUSH;
            S_PUSH:  if (!job_valid_reg || job_ready) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    logic [55:0] quo_sh;
    logic [31:0] lerp_res;
    assign quo_sh = {quo_reg[54:0], (rem_sh >= {33'd0, sweep_length})};
    assign lerp_res = down_reg ? base_reg - quo_reg[31:0] : base_reg + quo_reg[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= S_IDLE;
            idx_reg       <= '0;
            job_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (job_valid_reg && job_ready) job_valid_reg <= 1'b0;
            case (st_reg)
                S_IDLE: if (in_valid && in_ready) begin
                    restart_reg <= in_restart;
                    eff_idx_reg <= in_restart ? '0 : idx_reg;
                    inc_reg     <= s_w;
                    job_reg.number <= cur_idx;
                    job_reg.last   <= (sweep_length != 24'd0) &&
                        ({8'd0, (in_restart ? '0 : idx_reg)} == {8'd0, sweep_length} - 32'd1);
                    job_reg.restart <= in_restart;
                    if (in_restart) idx_reg <= (IMAX != 0) ? INDEX_BITS'(1) : '0;
                    else if (idx_reg != IMAX) idx_reg <= idx_reg + 1'b1;
                    m_reg   <= norm(s_w, msb_s);
                    la_reg  <= {msb_s, 16'd0};
                    cnt_reg <= 5'd0;
                end
                S_LOGA: begin
                    la_reg[15:0] <= {la_reg[14:0], sq_hi[31]};
                    if (cnt_reg == 5'd15) begin
                        // start the second operand
                        m_reg   <= norm(e_w, msb_e);
                        lb_reg  <= {msb_e, 16'd0};
                        cnt_reg <= 5'd0;
                    end else begin
                        m_reg   <= sq_hi[31] ? sq_hi >> 1 : sq_hi;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_LOGB: begin
                    if (sq_hi[31]) begin
                        m_reg <= sq_hi >> 1;
                        lb_reg[15:0] <= {lb_reg[14:0], 1'b1};
                    end else begin
                        m_reg <= sq_hi;
                        lb_reg[15:0] <= {lb_reg[14:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_LMUL: begin
                    num_reg  <= 56'(diff) * 56'(eff_idx_reg);
                    base_reg <= lo_a;
                    down_reg <= hi_b < lo_a;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    dcnt_reg <= 6'd0;
                    // past the end: hold the end value
                    r_reg    <= 32'd1 << 30;
                    cnt_reg  <= 5'd1;
                    frac_reg <= lb_reg[15:0];
                    n_reg    <= lb_reg[20:16];
                    if (past_end) inc_reg <= e_w;
                end
                S_DIV: begin
                    rem_reg  <= (rem_sh >= {33'd0, sweep_length}) ?
                                rem_sh - {33'd0, sweep_length} : rem_sh;
                    quo_reg  <= quo_sh;
                    num_reg  <= {num_reg[54:0], 1'b0};
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == 6'd55) begin
                        r_reg    <= 32'd1 << 30;
                        cnt_reg  <= 5'd1;
                        frac_reg <= down_reg ? 16'(base_reg - quo_sh[31:0])
                                             : 16'(base_reg + quo_sh[31:0]);
                        n_reg    <= down_reg ? 5'((base_reg - quo_sh[31:0]) >> 16)
                                             : 5'((base_reg + quo_sh[31:0]) >> 16);
                        inc_reg  <= down_reg ? base_reg - quo_sh[31:0]
                                             : base_reg + quo_sh[31:0];
                    end
                end
                S_EXP: begin
                    if (frac_reg[15]) r_reg <= rc[61:30];
                    frac_reg <= {frac_reg[14:0], 1'b0};
                    cnt_reg  <= cnt_reg + 1'b1;
                end
                S_RND: begin
                    if (sel == SWEEP_LOG) begin
                        if (vexp == 64'd0) inc_reg <= 32'd1;
                        else if (vexp > 64'hFFFF_FFFF) inc_reg <= 32'hFFFF_FFFF;
                        else inc_reg <= vexp[31:0];
                    end
                end
                S_PUSH: if (!job_valid_reg || job_ready) begin
                    job_valid_reg   <= 1'b1;
                    job_reg.inc     <= inc_reg;
                    job_reg.restart <= restart_reg;
                end
                default: ;
            endcase
        end
    end

    logic unused_ok;
    assign unused_ok = ^{lerp_res, msb};

endmodule

FILE: rtl/dds_fg_queue.sv
// ----------------------------------------------------------------------------
// dds_fg_queue
// Two-entry job queue between the increment front end and the sample back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dds_fg_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  dds_fg_pkg::job_t wr_job,
    output logic             rd_valid,
    input  logic             rd_ready,
    output dds_fg_pkg::job_t rd_job
);
    import dds_fg_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_job   = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr_valid && wr_ready) mem_reg[wp_reg] <= wr_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr_valid && wr_ready) wp_reg <= ~wp_reg;
            if (rd_valid && rd_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
        end
    end

endmodule

FILE: rtl/dds_fg_back.sv
// ----------------------------------------------------------------------------
// dds_fg_back
// Advances the carrier and AM accumulators, forms the wave and applies gain
// and AM with one shared multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dds_fg_back #(
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              job_valid,
    output logic                              job_ready,
    input  dds_fg_pkg::job_t                  job,
    input  logic [4:0]                        mode,
    input  logic [15:0]                       amplitude,
    input  logic [31:0]                       phase_offset,
    input  logic [31:0]                       mod_tuning_word,
    input  logic [15:0]                       mod_depth,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dds_fg_pkg::SAMPLE_W-1:0]   out_sample,
    output logic [dds_fg_pkg::NUMBER_W-1:0]   out_number,
    output logic                              out_last
);
    import dds_fg_pkg::*;

    localparam int TW = $clog2(SINE_TABLE_DEPTH);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_AMP  = 5'b00010,
        B_DEP  = 5'b00100,
        B_AM   = 5'b01000,
        B_OUT  = 5'b10000
    } bst_t;

    function automatic logic [PHASE_BITS-1:0] to_phase(input logic [31:0] w);
        if (PHASE_BITS >= 32) return PHASE_BITS'({w, {(PHASE_BITS-32+1){1'b0}}} >> 1);
        else return PHASE_BITS'(w >> (32 - PHASE_BITS));
    endfunction

    function automatic logic [31:0] top32(input logic [PHASE_BITS-1:0] p);
        if (PHASE_BITS >= 32) return 32'(p >> (PHASE_BITS - 32));
        else return 32'({p, 32'd0} >> PHASE_BITS);
    endfunction

    // table entry for a 32-bit cycle fraction: floor(v * depth / 2^32)
    function automatic logic [TW-1:0] tab_idx(input logic [31:0] v);
        return TW'((64'(v) * 64'(SINE_TABLE_DEPTH)) >> 32);
    endfunction

    // sine ROM, Q.16, read with registered data
    logic signed [17:0]    sine_rom [SINE_TABLE_DEPTH];

    initial begin
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) sine_rom[i] = sine_entry(i, SINE_TABLE_DEPTH);
    end

    bst_t                  st_reg;
    logic [PHASE_BITS-1:0] cph_reg, mph_reg;
    logic [31:0]           u_reg;
    logic signed [17:0]    cw_reg, sw_reg;
    logic                  neg_reg, sneg_reg;
    logic [16:0]           smag_reg;
    logic [31:0]           mag_reg;
    logic [16:0]           dm_reg;
    logic [NUMBER_W-1:0]   num_reg;
    logic                  last_reg;
    logic                  ov_reg;
    logic [SAMPLE_W-1:0]   os_reg;
    logic [NUMBER_W-1:0]   on_reg;
    logic                  ol_reg;

    logic [PHASE_BITS-1:0] cph_base, cph_new, mph_base;
    logic [31:0]           u;
    logic [TW-1:0]         cidx, midx;
    logic signed [17:0]    w, s;
    logic [16:0]           wmag;
    logic [31:0]           mul_a, mul_b;
    logic [63:0]           prod;
    logic [15:0]           amp, dep;
    logic [31:0]           mt;

    assign amp = (amplitude > AMP_MAX) ? AMP_MAX : amplitude;
    assign dep = (mod_depth > DEPTH_MAX) ? DEPTH_MAX : mod_depth;
    assign mt  = (mod_tuning_word == 32'd0) ? 32'd1 : mod_tuning_word;

    assign cph_base = job.restart ? to_phase(phase_offset) : cph_reg;
    assign mph_base = job.restart ? '0 : mph_reg;
    assign cph_new  = cph_base + to_phase(job.inc);
    assign u        = top32(cph_new);
    assign cidx     = tab_idx(u);
    assign midx     = tab_idx(top32(mph_base));

    // both sine lookups are taken as the job is accepted
    always_ff @(posedge aclk) begin
        if (st_reg == B_IDLE && job_valid) begin
            cw_reg <= sine_rom[cidx];
            sw_reg <= sine_rom[midx];
        end
    end

    always_comb begin
        case (mode[1:0])
            WAVE_SINE:     w = cw_reg;
            WAVE_SQUARE:   w = u_reg[31] ? -18'sd65536 : 18'sd65536;
            WAVE_TRIANGLE: w = u_reg[31] ? 18'(19'sd196608 - $signed({1'b0, u_reg[31:14]}))
                                         : 18'($signed({1'b0, u_reg[31:14]}) - 19'sd65536);
            default:       w = $signed({1'b0, u_reg[31:15]}) - 18'sd65536;
        endcase
    end

    assign wmag = 17'(w < 0 ? -w : w);
    assign s    = sw_reg;

    always_comb begin
        case (st_reg)
            B_AMP:   begin mul_a = 32'(amp);  mul_b = 32'(wmag); end
            B_DEP:   begin mul_a = 32'(dep);  mul_b = 32'(smag_reg); end
            B_AM:    begin
                mul_a = mag_reg;
                mul_b = sneg_reg ? 32'(ONE_Q16 - dm_reg) : 32'(ONE_Q16 + dm_reg);
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign prod = 64'(mul_a) * 64'(mul_b);

    assign job_ready  = (st_reg == B_IDLE);
    assign out_valid  = ov_reg;
    assign out_sample = os_reg;
    assign out_number = on_reg;
    assign out_last   = ol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= B_IDLE;
            cph_reg <= '0;
            mph_reg <= '0;
            ov_reg  <= 1'b0;
        end else begin
            if (ov_reg && out_ready) ov_reg <= 1'b0;
            case (st_reg)
                B_IDLE: if (job_valid) begin
                    cph_reg  <= cph_new;
                    mph_reg  <= mph_base;
                    u_reg    <= u;
                    num_reg  <= job.number;
                    last_reg <= job.last;
                    st_reg   <= B_AMP;
                end
                B_AMP: begin
                    mag_reg  <= 32'((prod + 64'd2048) >> 12);
                    neg_reg  <= w < 0;
                    sneg_reg <= s < 0;
                    smag_reg <= 17'(s < 0 ? -s : s);
                    st_reg   <= mode[4] ? B_DEP : B_OUT;
                end
                B_DEP: begin
                    dm_reg <= 17'((prod + 64'd16384) >> 15);
                    st_reg <= B_AM;
                end
                B_AM: begin
                    mag_reg <= 32'((prod + 64'd32768) >> 16);
                    st_reg  <= B_OUT;
                end
                B_OUT: if (!ov_reg || out_ready) begin
                    ov_reg  <= 1'b1;
                    os_reg  <= neg_reg ? SAMPLE_W'(-mag_reg) : SAMPLE_W'(mag_reg);
                    on_reg  <= num_reg;
                    ol_reg  <= last_reg;
                    mph_reg <= mph_reg + to_phase(mt);
                    st_reg  <= B_IDLE;
                end
                default: st_reg <= B_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/dds_function_generator_sweep_am_unit.sv
// ----------------------------------------------------------------------------
// dds_function_generator_sweep_am_unit
// DDS function generator with linear/log frequency sweep and optional AM.
// ----------------------------------------------------------------------------
// Each beat on s_axis asks for one sample (tdata[0] = restart). A front end
// works out the carrier increment: a linear sweep adds a serial divider and a
// log sweep adds two 16-step log2 loops and a 16-step exp2 loop. A two-entry
// queue lets the front work on the next beat while the back end advances both
// phase accumulators, looks up the wave and applies gain and AM through one
// shared multiplier. m_axis tdata carries the signed Q.16 sample (bits 21:0)
// and the burst index (45:22); m_axis_tlast marks the last index of a burst.
// Write config only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dds_function_generator_sweep_am_unit #(
    parameter int PHASE_BITS       = dds_fg_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = dds_fg_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int INDEX_BITS       = dds_fg_pkg::INDEX_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [0] restart
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [47:0]                       m_axis_tdata,   // [21:0] sample_value, [45:22] sample_number
    output logic                              m_axis_tlast,
    input  logic                              cfg_we,
    input  logic [dds_fg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [dds_fg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import dds_fg_pkg::*;

    logic [4:0]  mode_reg;
    logic [15:0] amp_reg, depth_reg;
    logic [31:0] pofs_reg, tune_reg, end_reg, mtune_reg;
    logic [23:0] len_reg;

    // register file, reset to the documented defaults
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 5'd0;
            amp_reg   <= 16'd4096;
            pofs_reg  <= 32'd0;
            tune_reg  <= 32'd97391;
            end_reg   <= 32'd97391;
            len_reg   <= 24'd1024;
            mtune_reg <= 32'd97;
            depth_reg <= 16'd16384;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MODE:      mode_reg  <= cfg_wdata[4:0];
                REG_AMPLITUDE: amp_reg   <= cfg_wdata[15:0];
                REG_PHASE_OFS: pofs_reg  <= cfg_wdata;
                REG_TUNE:      tune_reg  <= cfg_wdata;
                REG_SWEEP_END: end_reg   <= cfg_wdata;
                REG_SWEEP_LEN: len_reg   <= cfg_wdata[23:0];
                REG_MOD_TUNE:  mtune_reg <= cfg_wdata;
                REG_MOD_DEPTH: depth_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    job_t f_job, q_job;
    logic f_valid, f_ready, q_valid, q_ready;

    dds_fg_front #(.INDEX_BITS(INDEX_BITS)) u_front (
        .aclk, .aresetn,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_restart(s_axis_tdata[0]),
        .mode(mode_reg), .tuning_word(tune_reg), .sweep_end_word(end_reg),
        .sweep_length(len_reg),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    dds_fg_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_job(q_job)
    );

    logic [SAMPLE_W-1:0] sample;
    logic [NUMBER_W-1:0] number;

    dds_fg_back #(.PHASE_BITS(PHASE_BITS), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_back (
        .aclk, .aresetn,
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .mode(mode_reg), .amplitude(amp_reg), .phase_offset(pofs_reg),
        .mod_tuning_word(mtune_reg), .mod_depth(depth_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_sample(sample), .out_number(number), .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, number, sample};

    // a held output beat must not change under backpressure
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")
    // the last flag only ever comes with a valid beat of a nonzero burst length
    `ASSERT_CLK(a_last_len, aclk, aresetn, !(m_axis_tvalid && m_axis_tlast) || len_reg != 24'd0,
        "last flagged with zero burst length")
    // a job popped from the queue never carries an unknown increment
    `ASSERT_CLK(a_q_ready, aclk, aresetn, !(q_valid && q_ready) || !$isunknown(q_job.inc),
        "job popped with unknown increment")

endmodule

FILE: tb/sv/dds_fg_checker.sv
// ----------------------------------------------------------------------------
// dds_fg_checker
// Watches the config port and both streams of the DDS function generator,
// predicts every sample from its own copy of the registers and accumulators,
// and compares each output beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dds_fg_checker
    import dds_fg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [0] restart
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [47:0]           m_axis_tdata,   // [21:0] value, [45:22] number
    input  logic                  m_axis_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending
);

    typedef struct {
        logic [21:0] value;
        logic [23:0] number;
        logic        last;
    } sample_t;

    sample_t     sample_q[$];

    logic [4:0]  mode_r;
    logic [15:0] gain_r, depth_r;
    logic [31:0] ofs_r, tune_r, end_r, mtune_r;
    logic [23:0] len_r;
    logic [31:0] carrier_ph, mod_ph;
    logic [23:0] burst_idx;
    logic [63:0] root_c[1:16];

    function automatic logic [63:0] int_root(input logic [63:0] x_in);
        logic [63:0] x, res, b;
        x   = x_in;
        res = 0;
        b   = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    initial begin
        logic [63:0] c;
        c = int_root(64'd1 << 61);
        for (int i = 1; i <= 16; i++) begin
            root_c[i] = c;
            c = int_root(c << 30);
        end
    end

    // sine table entry k of 1024, Q.16
    function automatic longint sine_entry_q16(input logic [9:0] k);
        logic [63:0] u, r, x, x2, t, s;
        logic [1:0]  q;
        u = 64'(k) << 22;
        q = u[31:30];
        r = u & 64'h3FFF_FFFF;
        if (q[0]) r = 64'h4000_0000 - r;
        x  = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t  = 64'h4000_0000 - x2 / 110;
        t  = 64'h4000_0000 - ((x2 * t) >> 30) / 72;
        t  = 64'h4000_0000 - ((x2 * t) >> 30) / 42;
        t  = 64'h4000_0000 - ((x2 * t) >> 30) / 20;
        t  = 64'h4000_0000 - ((x2 * t) >> 30) / 6;
        s  = (((x * t) >> 30) + 8192) >> 14;
        if (s > 65536) s = 65536;
        return q[1] ? -longint'(s) : longint'(s);
    endfunction

    function automatic logic [63:0] ramp(input logic [63:0] a, b, i, n);
        if (n == 0 || i >= n) return b;
        if (b >= a) return a + ((b - a) * i) / n;
        return a - ((a - b) * i) / n;
    endfunction

    function automatic logic [63:0] log2_q16(input logic [63:0] w);
        int          msb;
        logic [63:0] m, f;
        msb = 0;
        f   = 0;
        while (msb < 31 && (w >> (msb + 1)) != 0) msb++;
        m = (msb <= 30) ? (w << (30 - msb)) : (w >> 1);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            f = f << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                f = f | 1;
            end
        end
        return (64'(msb) << 16) | f;
    endfunction

    function automatic logic [63:0] exp2_q16(input logic [63:0] l);
        logic [63:0] n, f, r, v;
        n = (l >> 16) & 31;
        f = l & 16'hFFFF;
        r = 64'd1 << 30;
        for (int i = 1; i <= 16; i++)
            if (f[16-i]) r = (r * root_c[i]) >> 30;
        if (n >= 30) v = r << (n - 30);
        else v = (r + (64'd1 << (29 - n))) >> (30 - n);
        if (v < 1) v = 1;
        if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
        return v;
    endfunction

    function automatic logic [31:0] carrier_step();
        logic [63:0] s, e;
        s = (tune_r == 0) ? 64'd1 : 64'(tune_r);
        e = (end_r == 0) ? 64'd1 : 64'(end_r);
        case (mode_r[3:2])
            SWEEP_LIN: return 32'(ramp(s, e, 64'(burst_idx), 64'(len_r)));
            SWEEP_LOG: return 32'(exp2_q16(ramp(log2_q16(s), log2_q16(e),
                                                64'(burst_idx), 64'(len_r))));
            default:   return s[31:0];
        endcase
    endfunction

    function automatic longint wave_at(input logic [31:0] ph);
        case (mode_r[1:0])
            WAVE_SINE:     return sine_entry_q16(ph[31:22]);
            WAVE_SQUARE:   return ph[31] ? -65536 : 65536;
            WAVE_TRIANGLE: return ph[31] ? 3 * 65536 - longint'(ph >> 14)
                                         : longint'(ph >> 14) - 65536;
            default:       return longint'(ph >> 15) - 65536;
        endcase
    endfunction

    task automatic predict_sample(input logic restart);
        sample_t     e;
        longint      w, s;
        logic [63:0] amp, mag, dep, dm, fac;
        logic        neg;
        if (restart) begin
            carrier_ph = ofs_r;
            mod_ph     = 0;
            burst_idx  = 0;
        end
        carrier_ph = carrier_ph + carrier_step();
        w   = wave_at(carrier_ph);
        neg = w < 0;
        amp = (gain_r > AMP_MAX) ? 64'(AMP_MAX) : 64'(gain_r);
        mag = (amp * 64'(neg ? -w : w) + 2048) >> 12;
        if (mode_r[4]) begin
            dep = (depth_r > DEPTH_MAX) ? 64'(DEPTH_MAX) : 64'(depth_r);
            s   = sine_entry_q16(mod_ph[31:22]);
            dm  = (dep * 64'(s < 0 ? -s : s) + 16384) >> 15;
            fac = (s < 0) ? 65536 - dm : 65536 + dm;
            mag = (mag * fac + 32768) >> 16;
        end
        mod_ph   = mod_ph + ((mtune_r == 0) ? 32'd1 : mtune_r);
        e.value  = neg ? 22'(-mag) : 22'(mag);
        e.number = burst_idx;
        e.last   = (len_r != 0) && (burst_idx == len_r - 1);
        if (burst_idx != 24'hFF_FFFF) burst_idx++;
        sample_q.push_back(e);
    endtask

    task automatic report(input string what, input logic [63:0] got, exp_v);
        $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, exp_v);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        sample_t e;
        if (!aresetn) begin
            mode_r = 0;  gain_r = 4096;  ofs_r = 0;
            tune_r = 97391;  end_r = 97391;  len_r = 1024;
            mtune_r = 97;  depth_r = 16384;
            carrier_ph = 0;  mod_ph = 0;  burst_idx = 0;
            fail_count = 0;
            sample_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_MODE:      mode_r  = cfg_wdata[4:0];
                    REG_AMPLITUDE: gain_r  = cfg_wdata[15:0];
                    REG_PHASE_OFS: ofs_r   = cfg_wdata;
                    REG_TUNE:      tune_r  = cfg_wdata;
                    REG_SWEEP_END: end_r   = cfg_wdata;
                    REG_SWEEP_LEN: len_r   = cfg_wdata[23:0];
                    REG_MOD_TUNE:  mtune_r = cfg_wdata;
                    REG_MOD_DEPTH: depth_r = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) predict_sample(s_axis_tdata[0]);
            if (m_axis_tvalid && m_axis_tready) begin
                if (sample_q.size() == 0) begin
                    report("unexpected beat", m_axis_tdata, 0);
                end else begin
                    e = sample_q.pop_front();
                    if (m_axis_tdata[21:0] !== e.value)
                        report("sample_value", m_axis_tdata[21:0], e.value);
                    if (m_axis_tdata[45:22] !== e.number)
                        report("sample_number", m_axis_tdata[45:22], e.number);
                    if (m_axis_tlast !== e.last)
                        report("tlast", m_axis_tlast, e.last);
                end
            end
        end
        pending = sample_q.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the DDS function generator: directed register
// settings covering every wave, sweep and AM corner, then randomized phases,
// most with random stream stalls on both sides. Checking lives in dds_fg_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import dds_fg_pkg::*;

    // cycles with no beat on either stream before the run is declared hung;
    // a log sweep beat takes the longest, plus receiver stalls
    localparam int HANG_LIMIT = 5000;
    // quiet cycles after the last expected beat before touching config
    localparam int DRAIN      = 150;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // [0] restart
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [47:0]           m_axis_tdata;   // [21:0] sample_value, [45:22] sample_number
    logic                  m_axis_tlast;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int          fail_count, pending;
    int          s_idle_pct, r_idle_pct;
    logic        s_beat_done;
    int          quiet_cycles;
    logic [31:0] regs[8];

    dds_function_generator_sweep_am_unit i_dut (.*);

    dds_fg_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // input beat taken at this edge; read by the sender at the next falling edge
    always @(posedge aclk) s_beat_done <= s_axis_tvalid && s_axis_tready;

    // receiver backpressure
    always @(negedge aclk)
        m_axis_tready <= aresetn && ($urandom_range(0, 99) >= r_idle_pct);

    // hang watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one sample request; returns at the falling edge after the beat is taken
    task automatic send_beat(input logic restart);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        do @(negedge aclk); while (!s_beat_done);
    endtask

    // stop sending and let the block go fully idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
    endtask

    task automatic load_regs();
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_ADDR_W'(i);
            cfg_wdata <= regs[i];
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // first beat restarts the burst; later ones restart with odds 1 in restart_odds
    task automatic run_burst(input int n, input int restart_odds);
        for (int i = 0; i < n; i++)
            send_beat(i == 0 || (restart_odds != 0 && $urandom_range(1, restart_odds) == 1));
    endtask

    task automatic directed(input logic [31:0] md, amp, ofs, tw, ew, len, mtw, dep,
                            input int n, input int odds);
        settle();
        regs[REG_MODE]      = md;
        regs[REG_AMPLITUDE] = amp;
        regs[REG_PHASE_OFS] = ofs;
        regs[REG_TUNE]      = tw;
        regs[REG_SWEEP_END] = ew;
        regs[REG_SWEEP_LEN] = len;
        regs[REG_MOD_TUNE]  = mtw;
        regs[REG_MOD_DEPTH] = dep;
        load_regs();
        run_burst(n, odds);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'hFFFF_FFFF;
            1:       return $urandom_range(0, 3);
            2:       return $urandom;
            default: return $urandom_range(1, 1 << 26);
        endcase
    endfunction

    initial begin
        logic [31:0] len;
        int          odds;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_idle_pct    = 32;
        r_idle_pct    = 47;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset values, plain sine
        directed({3'd0, 2'd0, WAVE_SINE}, 4096, 0, 97391, 97391, 1024, 97, 16384, 3, 0);
        // square, amplitude above range clamps, zero tuning word acts as one
        directed({3'd0, 2'd0, WAVE_SQUARE}, 16'hFFFF, 0, 0, 0, 1024, 97, 16384, 2, 0);
        // triangle, zero gain, all-ones words and offset
        directed({3'd0, 2'd0, WAVE_TRIANGLE}, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 1024, 32'hFFFF_FFFF, 0, 3, 0);
        // sawtooth, linear sweep of length one: last on index 0, then held at end
        directed({3'd0, SWEEP_LIN, WAVE_SAW}, 40960, 32'h4000_0000, 1000,
                 32'h0100_0000, 1, 97, 16384, 3, 0);
        // log sweep over the full word range, AM with depth above range
        directed({3'd1, SWEEP_LOG, WAVE_SINE}, 40960, 0, 1, 32'hFFFF_FFFF, 4, 0,
                 16'hFFFF, 5, 0);
        // linear down sweep, zero sweep length: sits at end, never last
        directed({3'd0, SWEEP_LIN, WAVE_TRIANGLE}, 8192, 0, 32'hFFFF_FFFF, 0, 0,
                 97, 0, 3, 0);
        // sweep selector three, full AM depth at top gain, restart mid-burst
        directed({3'd1, 2'd3, WAVE_SQUARE}, 40960, 0, 32'h1000_0000, 5, 3,
                 32'h2000_0000, 32768, 5, 2);

        for (int p = 0; p < 30; p++) begin
            if (p < 10) begin
                s_idle_pct = 32;  r_idle_pct = 47;
            end else if (p < 20) begin
                s_idle_pct = 47;  r_idle_pct = 32;
            end else begin
                s_idle_pct = 0;   r_idle_pct = 0;
            end
            settle();
            case ($urandom_range(0, 7))
                0:       len = 0;
                1:       len = $urandom_range(0, 24'hFF_FFFF);
                2:       len = 1;
                default: len = $urandom_range(2, 64);
            endcase
            regs[REG_MODE]      = $urandom_range(0, 31);
            case ($urandom_range(0, 5))
                0:       regs[REG_AMPLITUDE] = 0;
                1:       regs[REG_AMPLITUDE] = 40960;
                2:       regs[REG_AMPLITUDE] = $urandom_range(40961, 65535);
                default: regs[REG_AMPLITUDE] = $urandom_range(0, 40960);
            endcase
            regs[REG_PHASE_OFS] = $urandom;
            regs[REG_TUNE]      = pick_word();
            regs[REG_SWEEP_END] = pick_word();
            regs[REG_SWEEP_LEN] = len;
            regs[REG_MOD_TUNE]  = pick_word();
            case ($urandom_range(0, 5))
                0:       regs[REG_MOD_DEPTH] = 0;
                1:       regs[REG_MOD_DEPTH] = 32768;
                2:       regs[REG_MOD_DEPTH] = $urandom_range(32769, 65535);
                default: regs[REG_MOD_DEPTH] = $urandom_range(0, 32768);
            endcase
            load_regs();
            // mostly whole bursts with a restart near the end, some ragged ones
            odds = (len == 0 || len > 64) ? 24 : int'(len) + $urandom_range(0, 4);
            run_burst(60, odds);
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN) @(negedge aclk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/dds_fg_pkg.sv
rtl/dds_fg_front.sv
rtl/dds_fg_queue.sv
rtl/dds_fg_back.sv
rtl/dds_function_generator_sweep_am_unit.sv
tb/sv/dds_fg_checker.sv
tb/sv/tb_top.sv
